// File: hw/rtl/permutation_pair_cycle_filter_core_assert.svh
// Assertion macros used by the port-level checker of the cycle filter core.
// Depends on nothing; include by bare file name.
`ifndef PERMUTATION_PAIR_CYCLE_FILTER_CORE_ASSERT_SVH
`define PERMUTATION_PAIR_CYCLE_FILTER_CORE_ASSERT_SVH

// Assertion checked only outside reset.
`define PPCF_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ppcf assertion failed");

// Assertion checked also during reset.
`define PPCF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ppcf assertion failed");

`endif

// File: hw/rtl/ppcf_pkg.sv
// Package for the permutation pair cycle filter: point, mask and stage types.
// Depends on nothing.
`default_nettype none

package ppcf_pkg;

  localparam int DEGREE  = 12;
  localparam int PT_W    = 4;
  localparam int PERM_W  = DEGREE * PT_W;
  localparam int CNT_W   = 4;
  localparam int NSTG    = 5;    // closure slots before the output register

  typedef logic [PT_W-1:0]          pt_t;
  typedef logic [DEGREE-1:0]        mask_t;
  typedef pt_t  [DEGREE-1:0]        perm_t;
  typedef mask_t [DEGREE-1:0]       mat_t;

  // Work carried down the pipeline.
  typedef struct packed {
    logic [PERM_W-1:0] prod;
    logic              is_perm;
    perm_t             q;    // power of the product
    mat_t              cyc;  // points visited along each product cycle
    mat_t              adj;  // reachability under a and b
  } stage_t;

  function automatic logic valid_perm(input perm_t w);
    logic [15:0] used;
    logic        ok;
    used = '0;
    ok   = 1'b1;
    for (int i = 0; i < DEGREE; i++) begin
      if (w[i] >= pt_t'(DEGREE)) ok = 1'b0;
      if (used[w[i]]) ok = 1'b0;
      used[w[i]] = 1'b1;
    end
    return ok;
  endfunction

  function automatic logic [CNT_W-1:0] popcount(input mask_t m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < DEGREE; i++) n = n + CNT_W'(m[i]);
    return n;
  endfunction

  function automatic mask_t onehot(input pt_t v);
    return (v < pt_t'(DEGREE)) ? (mask_t'(1) << v) : '0;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ppcf_step.sv
// One doubling step: square the product power, extend cycle masks, square reachability.
// Depends on ppcf_pkg.
`default_nettype none

module ppcf_step (
  input  wire ppcf_pkg::stage_t d,
  output ppcf_pkg::stage_t      q
);

  always_comb begin
    q = d;
    for (int i = 0; i < ppcf_pkg::DEGREE; i++) begin
      if (d.q[i] < ppcf_pkg::pt_t'(ppcf_pkg::DEGREE)) begin
        q.q[i]   = d.q[d.q[i]];
        q.cyc[i] = d.cyc[i] | d.cyc[d.q[i]];
      end else begin
        q.q[i]   = '0;
        q.cyc[i] = d.cyc[i];
      end
      q.adj[i] = '0;
      for (int j = 0; j < ppcf_pkg::DEGREE; j++) begin
        if (d.adj[i][j]) q.adj[i] = q.adj[i] | d.adj[j];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/permutation_pair_cycle_filter_core.sv
// Top level of the permutation pair cycle filter: config registers and 6-slot pipeline.
// Depends on ppcf_pkg and ppcf_step.
//
//  channel | dir | handshake             | content
//  in_     | in  | in_tvalid/in_tready   | candidate permutation b
//  out_    | out | out_tvalid/out_tready | product, flags, counts
//  cfg_    | in  | APB psel/penable      | fixed_perm (addr 0), cycle_length (addr 8)
//
// One transaction per cycle unless stalled; results pass st_r[0..4] and out_tdata_r.
// The depth is set by four doubling steps of the cycle and reachability closures.
// Each slot holds while its successor is full and stalled; empty slots keep filling.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
`default_nettype none

module permutation_pair_cycle_filter_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,    // [47:0] candidate_perm
  output logic        out_tvalid,
  input  wire         out_tready,
  // [47:0] product_perm, [48] is_perm, [52:49] cycle_count, [53] cycles_uniform,
  // [57:54] orbit_size, [58] is_transitive, [59] accept, [63:60] zero
  output logic [63:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [47:0] fixed_perm_r;
  logic [3:0]  cycle_len_r;
  logic        cfg_wr;

  ppcf_pkg::stage_t st_r [ppcf_pkg::NSTG];
  ppcf_pkg::stage_t st_nxt [ppcf_pkg::NSTG];
  ppcf_pkg::stage_t st0_nxt;
  logic [ppcf_pkg::NSTG:0] vld_r;
  logic [ppcf_pkg::NSTG:0] en;
  logic [63:0]      out_tdata_r;
  logic [63:0]      out_tdata_nxt;
  ppcf_pkg::perm_t  a_pts;
  ppcf_pkg::perm_t  b_pts;

  // Configuration: paddr[3] selects the register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = cfg_paddr[3] ? {60'd0, cycle_len_r} : {16'd0, fixed_perm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_perm_r <= 48'hBA9876543210;
      cycle_len_r  <= 4'd4;
    end else if (cfg_wr) begin
      if (cfg_paddr[3]) cycle_len_r <= cfg_pwdata[3:0];
      else              fixed_perm_r <= cfg_pwdata[47:0];
    end
  end

  // Slot enables: load when empty or when the next slot moves.
  always_comb begin
    en[ppcf_pkg::NSTG] = ~vld_r[ppcf_pkg::NSTG] | out_tready;
    for (int k = ppcf_pkg::NSTG - 1; k >= 0; k--) en[k] = ~vld_r[k] | en[k+1];
  end
  assign in_tready  = en[0];
  assign out_tvalid = vld_r[ppcf_pkg::NSTG];
  assign out_tdata  = out_tdata_r;

  // Entry: form the product, check both bijections, seed the closures.
  assign a_pts = ppcf_pkg::perm_t'(fixed_perm_r);
  assign b_pts = ppcf_pkg::perm_t'(in_tdata);

  always_comb begin
    st0_nxt = '0;
    for (int i = 0; i < ppcf_pkg::DEGREE; i++) begin
      st0_nxt.q[i] = (b_pts[i] < ppcf_pkg::pt_t'(ppcf_pkg::DEGREE)) ?
                     a_pts[b_pts[i]] : '0;
      st0_nxt.prod[i*4 +: 4] = st0_nxt.q[i];
      st0_nxt.cyc[i] = ppcf_pkg::onehot(ppcf_pkg::pt_t'(i)) |
                       ppcf_pkg::onehot(st0_nxt.q[i]);
      st0_nxt.adj[i] = ppcf_pkg::onehot(ppcf_pkg::pt_t'(i)) |
                       ppcf_pkg::onehot(a_pts[i]) | ppcf_pkg::onehot(b_pts[i]);
    end
    st0_nxt.is_perm = ppcf_pkg::valid_perm(a_pts) & ppcf_pkg::valid_perm(b_pts);
  end

  assign st_nxt[0] = st0_nxt;

  // Four doubling steps between slots.
  for (genvar k = 1; k < ppcf_pkg::NSTG; k++) begin : g_step
    ppcf_step u_step (.d(st_r[k-1]), .q(st_nxt[k]));
  end

  // Finish: count cycles by their smallest point, check lengths, size the orbit.
  always_comb begin
    logic [3:0] cnt;
    logic       uni;
    logic [3:0] orb;
    logic       trn;
    logic       ok;
    cnt = '0;
    uni = 1'b1;
    for (int i = 0; i < ppcf_pkg::DEGREE; i++) begin
      if ((st_r[ppcf_pkg::NSTG-1].cyc[i] & ((ppcf_pkg::mask_t'(1) << i) - 1'b1)) == '0)
        cnt = cnt + 4'd1;
      if (ppcf_pkg::popcount(st_r[ppcf_pkg::NSTG-1].cyc[i]) != cycle_len_r) uni = 1'b0;
    end
    orb = ppcf_pkg::popcount(st_r[ppcf_pkg::NSTG-1].adj[0]);
    trn = (orb == 4'(ppcf_pkg::DEGREE));
    ok  = st_r[ppcf_pkg::NSTG-1].is_perm;
    out_tdata_nxt = {4'd0, ok & uni & trn, ok & trn, ok ? orb : 4'd0,
                     ok & uni, ok ? cnt : 4'd0, ok, st_r[ppcf_pkg::NSTG-1].prod};
  end

  // Advance valid bits; control state only under reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k <= ppcf_pkg::NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Payload: hold unless the slot loads.
  always_ff @(posedge clk) begin
    for (int k = 0; k < ppcf_pkg::NSTG; k++) begin
      if (en[k]) st_r[k] <= st_nxt[k];
    end
    if (en[ppcf_pkg::NSTG]) out_tdata_r <= out_tdata_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ppcf_checker.sv
// Port-level checker for the cycle filter core, bound to the top level.
// Depends on permutation_pair_cycle_filter_core_assert.svh.
`default_nettype none

`include "permutation_pair_cycle_filter_core_assert.svh"

module ppcf_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata
);

  `PPCF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)
  `PPCF_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `PPCF_ASSERT(a_accept_and, clk, rst_n, out_tvalid |-> (out_tdata[59] == (out_tdata[48] && out_tdata[53] && out_tdata[58])))
  `PPCF_ASSERT(a_invalid_zero, clk, rst_n, out_tvalid && !out_tdata[48] |-> (out_tdata[59:49] == 11'd0))
  `PPCF_ASSERT(a_trans_orbit, clk, rst_n, out_tvalid |-> (out_tdata[58] == (out_tdata[57:54] == 4'd12)))

endmodule

bind permutation_pair_cycle_filter_core ppcf_checker u_ppcf_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);

`default_nettype wire

// File: tb/permutation_pair_cycle_filter_checker.sv
// Checker for the permutation pair cycle filter: watches both streams and
// predicts each result from its own copy of the registers. Depends on ppcf_pkg.
`default_nettype none

module permutation_pair_cycle_filter_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [47:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [63:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [63:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] fixed_perm_q;
  logic [3:0]  cycle_len_q;
  logic [63:0] expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [3:0] nib_at(input logic [47:0] w, input int k);
    if (k >= 12) return 4'd0;
    return w[4*k +: 4];
  endfunction

  function automatic bit is_bijection(input logic [47:0] w);
    bit [15:0] used;
    int v;
    used = '0;
    for (int i = 0; i < ppcf_pkg::DEGREE; i++) begin
      v = nib_at(w, i);
      if (v >= ppcf_pkg::DEGREE || used[v]) return 0;
      used[v] = 1;
    end
    return 1;
  endfunction

  function automatic logic [63:0] filter_result(input logic [47:0] a, input logic [47:0] b,
                                                input logic [3:0] len);
    logic [3:0]  pv[16];
    logic [47:0] prod;
    bit          perm, uniform, trans;
    int          count, orbit, j, n;
    bit [15:0]   seen, reach, prev;
    prod = '0; count = 0; orbit = 0; uniform = 0; trans = 0;
    for (int i = 0; i < 16; i++) pv[i] = 4'd0;
    for (int i = 0; i < ppcf_pkg::DEGREE; i++) begin
      pv[i] = nib_at(a, nib_at(b, i));
      prod[4*i +: 4] = pv[i];
    end
    perm = is_bijection(a) && is_bijection(b);
    if (perm) begin
      seen = '0;
      uniform = 1;
      for (int i = 0; i < ppcf_pkg::DEGREE; i++) begin
        if (!seen[i]) begin
          j = i; n = 0;
          do begin
            seen[j] = 1; n++; j = pv[j];
          end while (j != i && n <= ppcf_pkg::DEGREE);
          count++;
          if (n != len) uniform = 0;
        end
      end
      reach = 16'd1; prev = '0;
      while (reach != prev) begin
        prev = reach;
        for (int i = 0; i < ppcf_pkg::DEGREE; i++)
          if (reach[i]) begin
            reach[nib_at(a, i)] = 1;
            reach[nib_at(b, i)] = 1;
          end
      end
      for (int i = 0; i < ppcf_pkg::DEGREE; i++) if (reach[i]) orbit++;
      trans = (orbit == ppcf_pkg::DEGREE);
    end
    return {4'd0, perm & uniform & trans, trans, orbit[3:0], uniform, count[3:0], perm,
            prod};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fixed_perm_q <= 48'hBA9876543210;
      cycle_len_q  <= 4'd4;
      fail_count   <= 0;
      result_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr == 4'd0) fixed_perm_q <= cfg_pwdata[47:0];
        else if (cfg_paddr == 4'd8) cycle_len_q <= cfg_pwdata[3:0];
      end
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          if (expected_results[0] !== out_tdata) begin
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", expected_results[0], out_tdata);
            fail_count <= fail_count + 1;
          end
          void'(expected_results.pop_front());
        end
      end
      if (in_tvalid && in_tready)
        expected_results.insert(expected_results.size(),
                                filter_result(fixed_perm_q, in_tdata, cycle_len_q));
    end
  end
endmodule

`default_nettype wire

// File: tb/permutation_pair_cycle_filter_core_tb.sv
// Testbench top for the permutation pair cycle filter core: clock, reset,
// APB register writes and stream stimulus. Depends on the core and the checker.
`default_nettype none

module permutation_pair_cycle_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [47:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  wire         in_tready, out_tvalid, cfg_pready;
  wire  [63:0] out_tdata, cfg_prdata;
  int          fail_count, pending, result_count;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  bit          recv_hold = 0;
  int          idle_cycles = 0;
  int          sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  permutation_pair_cycle_filter_core dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  permutation_pair_cycle_filter_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending, .result_count
  );

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout waiting for transactions");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [3:0] addr, input logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Drain: wait for all results, then let the pipeline settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Send one transaction, holding tvalid across back-to-back items.
  task automatic send_item(input logic [47:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Random bijection of 12 points by shuffle.
  function automatic logic [47:0] rand_perm();
    logic [3:0]  p[12];
    logic [3:0]  t;
    logic [47:0] w;
    int          k;
    for (int i = 0; i < 12; i++) p[i] = 4'(i);
    for (int i = 11; i > 0; i--) begin
      k = $urandom_range(i);
      t = p[i]; p[i] = p[k]; p[k] = t;
    end
    for (int i = 0; i < 12; i++) w[4*i +: 4] = p[i];
    return w;
  endfunction

  // Bijection made of cycles of length len (len divides 12), in shuffled order.
  function automatic logic [47:0] cycle_perm(input int len);
    logic [47:0] order, w;
    int          pt[12];
    order = rand_perm();
    for (int i = 0; i < 12; i++) pt[i] = order[4*i +: 4];
    for (int i = 0; i < 12; i++)
      w[4*pt[i] +: 4] = 4'(pt[(i % len == len - 1) ? i - len + 1 : i + 1]);
    return w;
  endfunction

  // Mostly bijections, with some broken ones: a repeat, an out-of-range nibble or a random word.
  function automatic logic [47:0] rand_candidate();
    logic [47:0] w;
    int          r;
    r = $urandom_range(99);
    if (r < 10) return 48'({$urandom, $urandom});
    w = rand_perm();
    if (r < 18) w[4*$urandom_range(11) +: 4] = 4'($urandom_range(15, 12));
    else if (r < 26) w[4*$urandom_range(11) +: 4] = w[4*$urandom_range(11) +: 4];
    return w;
  endfunction

  int lens[6] = '{1, 2, 3, 4, 6, 12};
  int len;
  logic [47:0] a_sel;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers (identity a), then extremes and broken inputs.
    send_item(48'hBA9876543210);
    send_item(48'h0);
    send_item(48'hFFFFFFFFFFFF);
    send_item(48'h0123456789AB);
    send_item(48'h3210BA987654);
    send_item(48'hBA987654321C);
    send_item(48'hBA9876543200);
    send_item(cycle_perm(4));
    send_item(cycle_perm(12));
    end_burst();
    drain();
    // Cycle length without meaning, and the other extremes.
    reg_write(4'd8, 64'd0);
    send_item(cycle_perm(1));
    send_item(48'hBA9876543210);
    end_burst(); drain();
    reg_write(4'd8, 64'd15);
    send_item(cycle_perm(12));
    end_burst(); drain();
    reg_write(4'd8, 64'd12);
    send_item(cycle_perm(12));
    send_item(48'h0123456789AB);
    end_burst(); drain();
    reg_write(4'd8, 64'd1);
    send_item(48'hBA9876543210);
    end_burst(); drain();
    // Broken fixed permutations: all ones, all zeros, one repeat.
    reg_write(4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(48'hBA9876543210);
    end_burst(); drain();
    reg_write(4'd0, 64'd0);
    send_item(48'hBA9876543210);
    end_burst(); drain();
    reg_write(4'd0, 64'hBA9876543211);
    send_item(48'hBA9876543210);
    end_burst(); drain();

    // Pressure: hold off the receiver while the sender keeps offering.
    reg_write(4'd0, {16'd0, rand_perm()});
    recv_hold = 1;
    fork
      begin
        for (int i = 0; i < 20; i++) send_item(rand_candidate());
        end_burst();
      end
      begin
        repeat (60) @(posedge clk);
        recv_hold = 0;
      end
    join
    drain();

    // Random phases with changing registers and idle mixes.
    for (int ph = 0; ph < 24; ph++) begin
      if (ph < 8) begin send_idle_pct = 12; recv_idle_pct = 62; end
      else if (ph < 16) begin send_idle_pct = 62; recv_idle_pct = 12; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      len = lens[$urandom_range(5)];
      a_sel = ($urandom_range(9) == 0) ? rand_candidate() : rand_perm();
      reg_write(4'd0, {$urandom, $urandom});
      reg_write(4'd0, {16'd0, a_sel});
      reg_write(4'd8, 64'(($urandom_range(9) == 0) ? $urandom_range(15) : len));
      for (int i = 0; i < 58; i++) begin
        if ($urandom_range(1) == 0 && a_sel == 48'hBA9876543210)
          send_item(cycle_perm(len));
        else send_item(rand_candidate());
        if ($urandom_range(15) == 0) end_burst();
      end
      end_burst();
      drain();
    end

    $display("run covered %0d candidates, %0d results, over 24 random register settings",
             sent, result_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: permutation_pair_cycle_filter_core.f
+incdir+hw/rtl
hw/rtl/ppcf_pkg.sv
hw/rtl/ppcf_step.sv
hw/rtl/permutation_pair_cycle_filter_core.sv
hw/rtl/ppcf_checker.sv
tb/permutation_pair_cycle_filter_checker.sv
tb/permutation_pair_cycle_filter_core_tb.sv
